[src/sfla_pkg.sv]
`default_nettype none

package sfla_pkg;

    localparam int unsigned SLOTS   = 1024;
    localparam int unsigned SLOT_W  = 10;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned TOTAL_W = 32;

    typedef enum logic {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_RELEASE = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot_index;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_given;
        t_status             status;
        logic [COUNT_W-1:0]  live_count;
        logic [COUNT_W-1:0]  peak_count;
        logic [TOTAL_W-1:0]  alloc_total;
        logic [TOTAL_W-1:0]  release_total;
    } t_rsp;

endpackage

`default_nettype wire

[src/sfla_fwd_ram.sv]
`default_nettype none

module sfla_fwd_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem [DEPTH];

    logic [DW-1:0] r_rd_data;
    logic [AW-1:0] r_rd_addr;
    logic          r_fw_vld;
    logic [AW-1:0] r_fw_addr;
    logic [DW-1:0] r_fw_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // last write kept so a read issued on the same edge sees the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else if (i_we) begin
            r_fw_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_fw_addr <= i_wr_addr;
            r_fw_data <= i_wr_data;
        end
    end

    assign o_rd_data = (r_fw_vld && r_fw_addr == r_rd_addr) ? r_fw_data : r_rd_data;

endmodule

`default_nettype wire

[src/slot_free_list_allocator.sv]
// channel   | direction | handshake                  | payload
// request   | in        | start high and busy low    | i_req (kind, slot_index)
// result    | out       | o_valid, one cycle, no stall | o_rsp (slot, status, counts)
//
// one request per cycle while busy is low; the result of a request taken passes
// through the registered live map and free stack reads, the compute logic and then
// the result register. busy is high during reset and in the cycle after it.
// synchronous active-low reset clears counts and the free stack pointer; the live
// map is gated by the peak count, so it needs no clearing pass.
// the result side cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module slot_free_list_allocator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire sfla_pkg::t_req i_req,
    output logic               busy,
    output logic               o_valid,
    output sfla_pkg::t_rsp     o_rsp
);

    import sfla_pkg::*;

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    logic          r_busy;
    logic          r_req_vld;
    t_req          r_req;
    logic [CW-1:0] r_top,  n_top;
    logic [CW-1:0] r_live, n_live;
    logic [CW-1:0] r_peak, n_peak;
    logic [TOTAL_W-1:0] r_alloc, n_alloc;
    logic [TOTAL_W-1:0] r_rel,   n_rel;
    logic          r_rsp_vld;
    t_rsp          r_rsp,  n_rsp;

    logic          accept;
    logic          map_bit;
    logic [IW-1:0] stk_data;
    logic          map_we;
    logic [IW-1:0] map_wr_addr;
    logic          map_wr_data;
    logic          stk_we;
    logic [IW-1:0] stk_wr_addr;
    logic [IW-1:0] stk_rd_addr;

    logic          stk_empty;
    logic          full;
    logic          idx_ok;
    logic          slot_live;
    logic [IW-1:0] alloc_slot;
    logic [CW-1:0] live_inc;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_top     <= '0;
            r_live    <= '0;
            r_peak    <= '0;
            r_alloc   <= '0;
            r_rel     <= '0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= accept;
            r_rsp_vld <= r_req_vld;
            r_top     <= n_top;
            r_live    <= n_live;
            r_peak    <= n_peak;
            r_alloc   <= n_alloc;
            r_rel     <= n_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    sfla_fwd_ram #(
        .DEPTH (SLOTS),
        .AW    (IW),
        .DW    (1)
    ) u_live_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (IW'(i_req.slot_index)),
        .i_we      (map_we),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (map_wr_data),
        .o_rd_data (map_bit)
    );

    sfla_fwd_ram #(
        .DEPTH (SLOTS),
        .AW    (IW),
        .DW    (IW)
    ) u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (stk_rd_addr),
        .i_we      (stk_we),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (IW'(r_req.slot_index)),
        .o_rd_data (stk_data)
    );

    // the top after this request is where the next pop reads
    assign stk_rd_addr = IW'(n_top - CW'(1));

    assign stk_empty  = (r_top == '0);
    assign full       = stk_empty && (r_live == CW'(SLOTS));
    assign idx_ok     = 32'(r_req.slot_index) < 32'(SLOTS);
    // entries at or above the peak were never handed out, so they read as not live
    assign slot_live  = idx_ok && (32'(r_req.slot_index) < 32'(r_peak)) && map_bit;
    assign alloc_slot = stk_empty ? r_live[IW-1:0] : stk_data;
    assign live_inc   = r_live + CW'(1);
    assign stk_wr_addr = r_top[IW-1:0];

    always_comb begin
        n_top       = r_top;
        n_live      = r_live;
        n_peak      = r_peak;
        n_alloc     = r_alloc;
        n_rel       = r_rel;
        map_we      = 1'b0;
        map_wr_addr = alloc_slot;
        map_wr_data = 1'b1;
        stk_we      = 1'b0;
        n_rsp.slot_given = '0;
        n_rsp.status     = ST_IGNORED;

        if (r_req_vld) begin
            case (r_req.kind)
                KIND_ALLOC: begin
                    if (full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        map_we  = 1'b1;
                        n_live  = live_inc;
                        n_peak  = (live_inc > r_peak) ? live_inc : r_peak;
                        n_alloc = r_alloc + TOTAL_W'(1);
                        if (!stk_empty) begin
                            n_top = r_top - CW'(1);
                        end
                        n_rsp.slot_given = SLOT_W'(alloc_slot);
                        n_rsp.status     = ST_ALLOC;
                    end
                end
                KIND_RELEASE: begin
                    if (slot_live) begin
                        map_we      = 1'b1;
                        map_wr_addr = IW'(r_req.slot_index);
                        map_wr_data = 1'b0;
                        stk_we      = 1'b1;
                        n_top       = r_top + CW'(1);
                        n_live      = r_live - CW'(1);
                        n_rel       = r_rel + TOTAL_W'(1);
                        n_rsp.status = ST_RELEASE;
                    end
                end
                default: begin
                    n_rsp.status = ST_IGNORED;
                end
            endcase
        end

        n_rsp.live_count    = COUNT_W'(n_live);
        n_rsp.peak_count    = COUNT_W'(n_peak);
        n_rsp.alloc_total   = n_alloc;
        n_rsp.release_total = n_rel;
    end

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

    // every slot below the peak is either live or on the free stack
    a_slots_accounted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_live) + 32'(r_top)) == 32'(r_peak))
        else $error("live plus free does not match peak");

    a_live_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_peak)
        else $error("live count above peak");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a request two cycles earlier");

    a_full_only_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_FULL) |-> o_rsp.live_count == COUNT_W'(SLOTS))
        else $error("full reported below capacity");

endmodule

`default_nettype wire

[tb/sv/slot_free_list_allocator_checker.sv]
module slot_free_list_allocator_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  sfla_pkg::t_req i_req,
    input  logic           i_valid,
    input  sfla_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfla_pkg::*;

    // own copy of the allocator state
    bit                 slot_held [SLOTS];
    logic [SLOT_W-1:0]  freed_slots [SLOTS];
    int unsigned        freed_depth;
    int unsigned        in_use;
    int unsigned        high_water;
    logic [TOTAL_W-1:0] grants;
    logic [TOTAL_W-1:0] returns;

    t_rsp pending_replies [$];

    task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                   input logic [TOTAL_W-1:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic check_field(input string what, input logic [TOTAL_W-1:0] got,
                               input logic [TOTAL_W-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic compute_slot_reply(input t_req req, output t_rsp rsp);
        int unsigned pick;
        bit          found;
        rsp   = '0;
        pick  = 0;
        found = 1'b1;
        if (req.kind == KIND_ALLOC) begin
            // recently freed slot first, otherwise the next never-used one
            if (freed_depth > 0) begin
                freed_depth--;
                pick = freed_slots[freed_depth];
            end else if (in_use < SLOTS) begin
                pick = in_use;
            end else begin
                found = 1'b0;
            end
            if (found && pick < SLOTS) begin
                slot_held[pick] = 1'b1;
                in_use++;
                grants++;
                if (in_use > high_water) begin
                    high_water = in_use;
                end
                rsp.slot_given = pick[SLOT_W-1:0];
                rsp.status     = ST_ALLOC;
            end else begin
                rsp.status = ST_FULL;
            end
        end else if (req.slot_index < SLOTS && slot_held[req.slot_index]
                     && freed_depth < SLOTS && in_use != 0) begin
            slot_held[req.slot_index] = 1'b0;
            freed_slots[freed_depth]  = req.slot_index;
            freed_depth++;
            in_use--;
            returns++;
            rsp.status = ST_RELEASE;
        end else begin
            rsp.status = ST_IGNORED;
        end
        rsp.live_count    = in_use[COUNT_W-1:0];
        rsp.peak_count    = high_water[COUNT_W-1:0];
        rsp.alloc_total   = grants;
        rsp.release_total = returns;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_rsp fresh;
        t_rsp want;
        if (!i_rst_n) begin
            foreach (slot_held[n]) begin
                slot_held[n] = 1'b0;
            end
            freed_depth = 0;
            in_use      = 0;
            high_water  = 0;
            grants      = '0;
            returns     = '0;
            pending_replies.delete();
        end else begin
            if (i_start && !i_busy) begin
                compute_slot_reply(i_req, fresh);
                pending_replies.push_back(fresh);
            end
            if (i_valid) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("result with no request waiting", i_rsp.status, 0);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("slot_given", i_rsp.slot_given, want.slot_given);
                    check_field("status", i_rsp.status, want.status);
                    check_field("live_count", i_rsp.live_count, want.live_count);
                    check_field("peak_count", i_rsp.peak_count, want.peak_count);
                    check_field("alloc_total", i_rsp.alloc_total, want.alloc_total);
                    check_field("release_total", i_rsp.release_total, want.release_total);
                end
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

[tb/sv/slot_free_list_allocator_tb.sv]
module slot_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfla_pkg::*;

    localparam int          QUIET_LIMIT = 1000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    int fail_count;
    int pending;

    bit                idling_on;
    int                sent;
    int                n_granted;
    int                n_returned;
    int                n_ignored;
    int                n_full;
    int                quiet;
    logic [SLOT_W-1:0] held_slots [$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    slot_free_list_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    slot_free_list_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // slots handed out, so that most releases name a live slot
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            case (o_rsp.status)
                ST_ALLOC: begin
                    held_slots.push_back(o_rsp.slot_given);
                    n_granted++;
                end
                ST_RELEASE: n_returned++;
                ST_IGNORED: n_ignored++;
                default:    n_full++;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet <= 0;
        end else if (quiet + 1 >= QUIET_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic issue(input t_kind kind, input logic [SLOT_W-1:0] idx);
        t_req req;
        req.kind       = kind;
        req.slot_index = idx;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    task automatic pause_maybe();
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
                i_req <= t_req'($urandom);
            end
        end
    endtask

    task automatic random_request(input int alloc_pct);
        t_kind             kind;
        logic [SLOT_W-1:0] idx;
        int                k;
        idx = SLOT_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(0, 99) < alloc_pct) begin
            kind = KIND_ALLOC;
        end else begin
            kind = KIND_RELEASE;
            // mostly a live slot, otherwise any index as noise
            if (held_slots.size() > 0 && $urandom_range(0, 99) < 80) begin
                k   = $urandom_range(0, held_slots.size() - 1);
                idx = held_slots[k];
                held_slots.delete(k);
            end
        end
        pause_maybe();
        issue(kind, idx);
    endtask

    initial begin
        int fill_items;
        start      = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        idling_on  = 1'b0;
        sent       = 0;
        n_granted  = 0;
        n_returned = 0;
        n_ignored  = 0;
        n_full     = 0;
        quiet      = 0;
        fill_items = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // releases of slots never handed out, then allocations, releases and pops from the free stack
        issue(KIND_RELEASE, 10'd0);
        issue(KIND_RELEASE, 10'h3FF);
        issue(KIND_ALLOC, 10'h3FF);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_ALLOC, 10'h2AA);
        issue(KIND_RELEASE, 10'd1);
        issue(KIND_RELEASE, 10'd1);
        issue(KIND_RELEASE, 10'd2);
        issue(KIND_ALLOC, 10'h155);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_RELEASE, 10'd0);
        issue(KIND_RELEASE, 10'd3);
        issue(KIND_RELEASE, 10'd2);
        issue(KIND_RELEASE, 10'd1);
        issue(KIND_RELEASE, 10'd1);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_ALLOC, 10'd0);
        issue(KIND_RELEASE, 10'h2AA);

        idling_on = 1'b1;
        repeat (100) random_request(55);

        // drive the pool to capacity and keep asking past it
        while (n_full < 4 && fill_items < 1600) begin
            random_request(94);
            fill_items++;
        end

        repeat (60) random_request(20);
        idling_on = 1'b0;
        repeat (100) random_request(35);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);

        $display("%0d requests: %0d slots handed out, %0d given back", sent, n_granted,
                 n_returned);
        $display("%0d releases ignored, %0d allocations refused as full", n_ignored, n_full);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
